// ----- rtl/nwcs_pkg.sv -----
package nwcs_pkg;

   // operation codes of a request
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_NEAR  = 2'd1;
   localparam logic [1:0] OP_LEVEL = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Z   = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
   localparam logic [2:0] REG_GRID_W     = 3'd3;
   localparam logic [2:0] REG_GRID_H     = 3'd4;
   localparam logic [2:0] REG_NEAR_RAD   = 3'd5;
   localparam logic [2:0] REG_LEVEL_RAD  = 3'd6;
   localparam logic [2:0] REG_HEIGHT_TOL = 3'd7;

   // floored quotient and non-negative remainder of the cell divider
   typedef struct packed {
      logic signed [33:0] quo;
      logic [15:0]        rem;
   } div_res_type;

endpackage

// ----- rtl/nwcs_req_if.sv -----
interface nwcs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [15:0]        cell_index;
   logic               base_walkable;
   logic               blocked;
   logic signed [31:0] cell_height;
   logic signed [31:0] query_x;
   logic signed [31:0] query_z;

   modport source (output valid, operation, cell_index, base_walkable, blocked,
                   cell_height, query_x, query_z, input ready);
   modport sink (input valid, operation, cell_index, base_walkable, blocked,
                 cell_height, query_x, query_z, output ready);
endinterface

// ----- rtl/nwcs_rsp_if.sv -----
interface nwcs_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [15:0]        out_cell_index;
   logic signed [31:0] out_x;
   logic signed [31:0] out_z;
   logic signed [31:0] out_height;

   modport source (output valid, found, out_cell_index, out_x, out_z, out_height,
                   input ready);
   modport sink (input valid, found, out_cell_index, out_x, out_z, out_height,
                 output ready);
endinterface

// ----- rtl/nwcs_divider.sv -----
module nwcs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [32:0]    num,
   input  logic [15:0]           den,
   output logic                  done,
   output nwcs_pkg::div_res_type res
);

   logic        busy_ff, fix_ff, done_ff, neg_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] dvd_ff;
   logic [15:0] rem_ff, den_ff;
   nwcs_pkg::div_res_type res_ff;
   logic [16:0] trial, diff;
   logic        ge;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[32]};
      ge    = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
            neg_ff  <= num[32];
            dvd_ff  <= num[32] ? 33'(-num) : 33'(num);
            rem_ff  <= 16'd0;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[15:0] : trial[15:0];
            dvd_ff <= {dvd_ff[31:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            // round the quotient toward minus infinity
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (!neg_ff) begin
               res_ff.quo <= $signed({1'b0, dvd_ff});
               res_ff.rem <= rem_ff;
            end else if (rem_ff == 16'd0) begin
               res_ff.quo <= -$signed({1'b0, dvd_ff});
               res_ff.rem <= 16'd0;
            end else begin
               res_ff.quo <= $signed(~{1'b0, dvd_ff});
               res_ff.rem <= den_ff - rem_ff;
            end
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ----- rtl/nwcs_cell_store.sv -----
module nwcs_cell_store #(
   parameter int  DEPTH = 65536,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [32:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [32:0]   rdata,
   output logic          clearing
);

   logic [32:0]   mem [DEPTH];
   logic [32:0]   rdata_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   // sweep every entry to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) clr_ff <= 1'b0;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_ff) mem[clr_cnt_ff] <= '0;
      else if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata    = rdata_ff;
   assign clearing = clr_ff;

endmodule

// ----- rtl/nearest_walkable_cell_search_core.sv -----
// Grid cell store with nearest usable cell search.
// req_ch carries one operation per transfer: a cell write, a query or a no-op.
// rsp_ch returns exactly one result per request, in order; writes, no-ops and
// misses return found 0 with all other fields 0. csr_* writes configuration;
// the user must write it only while idle, as the block does not enforce this.
// A write is answered in the cycle after its transfer. A query runs two
// sequential divisions (33 restoring steps, a sign fix and the handoff each)
// that floor the point to its centre cell, checks the grid in S_REF (plus the
// height read in S_REFW for a same-level query), then issues one cell store
// read per cycle over each ring (8r cells, 1 for ring 0) and lets the read and
// distance pipeline drain after each ring; S_FIN1 (on a hit) and S_FIN2 form
// the result. The single read port of the cell store sets the rate.
// Reset loads register defaults and then sweeps the cell store to zero,
// during which no request is taken. A stalled result sits in the output
// register; the block takes the next request once that register is free or
// being drained in the same cycle.
module nearest_walkable_cell_search_core #(
   parameter int MAX_CELLS  = 65536,
   parameter int MAX_RADIUS = 64
) (
   input  logic        clock,
   input  logic        reset,
   nwcs_req_if.sink    req_ch,
   nwcs_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_DIVX = 8'b00000010,
      S_DIVZ = 8'b00000100,
      S_REF  = 8'b00001000,
      S_REFW = 8'b00010000,
      S_SCAN = 8'b00100000,
      S_FIN1 = 8'b01000000,
      S_FIN2 = 8'b10000000
   } state_type;

   state_type st_ff;

   // configuration registers
   logic [31:0] ox_ff, oz_ff;
   logic [15:0] cs_ff, tol_ff;
   logic [10:0] gw_ff, gh_ff;
   logic [6:0]  nr_ff, lr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff  <= 32'd0;
         oz_ff  <= 32'd0;
         cs_ff  <= 16'd256;
         gw_ff  <= 11'd256;
         gh_ff  <= 11'd256;
         nr_ff  <= 7'd12;
         lr_ff  <= 7'd20;
         tol_ff <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            nwcs_pkg::REG_ORIGIN_X:   ox_ff  <= csr_wdata;
            nwcs_pkg::REG_ORIGIN_Z:   oz_ff  <= csr_wdata;
            nwcs_pkg::REG_CELL_SIZE:  cs_ff  <= csr_wdata[15:0];
            nwcs_pkg::REG_GRID_W:     gw_ff  <= csr_wdata[10:0];
            nwcs_pkg::REG_GRID_H:     gh_ff  <= csr_wdata[10:0];
            nwcs_pkg::REG_NEAR_RAD:   nr_ff  <= csr_wdata[6:0];
            nwcs_pkg::REG_LEVEL_RAD:  lr_ff  <= csr_wdata[6:0];
            nwcs_pkg::REG_HEIGHT_TOL: tol_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [15:0] cs_eff;
   logic [21:0] grid_area;
   logic        grid_ok_ff;

   assign cs_eff    = (cs_ff == 16'd0) ? 16'd1 : cs_ff;
   assign grid_area = 22'(gw_ff) * 22'(gh_ff);

   // grid size check, settled long before a query needs it
   always_ff @(posedge clock) begin
      grid_ok_ff <= (gw_ff != 11'd0) && (gh_ff != 11'd0) &&
                    (32'(grid_area) <= 32'(MAX_CELLS));
   end

   // request handshake
   logic rsp_v_ff, req_fire, is_query, clearing;
   assign req_ch.ready = (st_ff == S_IDLE) && !clearing && (!rsp_v_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_query     = (req_ch.operation == nwcs_pkg::OP_NEAR) ||
                         (req_ch.operation == nwcs_pkg::OP_LEVEL);

   // cell store
   logic          store_we;
   logic [AW-1:0] store_raddr;
   logic [32:0]   store_rdata;

   assign store_we = req_fire && (req_ch.operation == nwcs_pkg::OP_WRITE) &&
                     ({16'd0, req_ch.cell_index} < 32'(MAX_CELLS));

   nwcs_cell_store #(.DEPTH(MAX_CELLS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .we       (store_we),
      .waddr    (AW'(req_ch.cell_index)),
      .wdata    ({req_ch.base_walkable & ~req_ch.blocked, req_ch.cell_height}),
      .raddr    (store_raddr),
      .rdata    (store_rdata),
      .clearing (clearing)
   );

   // shared divider for both axes
   logic                  div_start, div_done;
   logic signed [32:0]    div_num;
   nwcs_pkg::div_res_type div_res;
   logic signed [31:0]    qz_ff;

   always_comb begin
      div_start = 1'b0;
      div_num   = $signed({req_ch.query_x[31], req_ch.query_x}) -
                  $signed({ox_ff[31], ox_ff});
      if (st_ff == S_IDLE) begin
         div_start = req_fire && is_query;
      end else if (st_ff == S_DIVX) begin
         div_start = div_done;
         div_num   = $signed({qz_ff[31], qz_ff}) - $signed({oz_ff[31], oz_ff});
      end
   end

   nwcs_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cs_eff),
      .done  (div_done),
      .res   (div_res)
   );

   // query context
   logic               same_ff;
   logic signed [33:0] ccx_ff, ccz_ff;
   logic [15:0]        remx_ff, remz_ff;
   logic [6:0]         rad_ff, r_ff;
   logic [31:0]        ref_ff;
   logic [6:0]         rad_sel;
   logic               centre_in;
   logic [21:0]        ref_addr;

   assign rad_sel   = same_ff ? lr_ff : nr_ff;
   assign centre_in = (ccx_ff >= 34'sd0) && (ccx_ff < $signed({23'd0, gw_ff})) &&
                      (ccz_ff >= 34'sd0) && (ccz_ff < $signed({23'd0, gh_ff}));
   assign ref_addr  = 22'(ccz_ff[10:0]) * 22'(gw_ff) + 22'(ccx_ff[10:0]);

   // ring offset generator
   logic              gen_act_ff;
   logic signed [7:0] dx_ff, dz_ff, pos_r, neg_r, neg_r_nx;
   logic              gen_last, edge_row;

   assign pos_r    = $signed({1'b0, r_ff});
   assign neg_r    = -pos_r;
   assign neg_r_nx = -$signed({1'b0, r_ff + 7'd1});
   assign gen_last = (dx_ff == pos_r) && (dz_ff == pos_r);
   assign edge_row = (dz_ff == neg_r) || (dz_ff == pos_r);

   // stage a: absolute cell coordinates
   logic               a_v_ff, a_last_ff;
   logic signed [7:0]  a_dx_ff, a_dz_ff;
   logic signed [34:0] a_cx_ff, a_cz_ff;

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else a_v_ff <= gen_act_ff;
      a_last_ff <= gen_last;
      a_dx_ff   <= dx_ff;
      a_dz_ff   <= dz_ff;
      a_cx_ff   <= 35'(ccx_ff) + 35'(dx_ff);
      a_cz_ff   <= 35'(ccz_ff) + 35'(dz_ff);
   end

   // stage b: bounds and store address, read issued here
   logic        a_inb;
   logic [21:0] a_addr;
   assign a_inb  = (a_cx_ff >= 35'sd0) && (a_cx_ff < $signed({24'd0, gw_ff})) &&
                   (a_cz_ff >= 35'sd0) && (a_cz_ff < $signed({24'd0, gh_ff}));
   assign a_addr = 22'(a_cz_ff[10:0]) * 22'(gw_ff) + 22'(a_cx_ff[10:0]);
   assign store_raddr = (st_ff == S_REF) ? AW'(ref_addr) : AW'(a_addr);

   logic              b_v_ff, b_last_ff, b_inb_ff;
   logic signed [7:0] b_dx_ff, b_dz_ff;
   logic [10:0]       b_cx_ff, b_cz_ff;
   logic [AW-1:0]     b_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else b_v_ff <= a_v_ff;
      b_last_ff <= a_last_ff;
      b_inb_ff  <= a_inb;
      b_dx_ff   <= a_dx_ff;
      b_dz_ff   <= a_dz_ff;
      b_cx_ff   <= a_cx_ff[10:0];
      b_cz_ff   <= a_cz_ff[10:0];
      b_idx_ff  <= AW'(a_addr);
   end

   // stage c: usability, height window and doubled offsets
   logic signed [32:0] lvl_diff;
   logic               lvl_ok, b_hit;
   logic signed [25:0] mul_x, mul_z;
   logic signed [26:0] ddx_in, ddz_in;

   assign lvl_diff = $signed({store_rdata[31], store_rdata[31:0]}) -
                     $signed({ref_ff[31], ref_ff});
   assign lvl_ok   = (lvl_diff <= $signed({17'd0, tol_ff})) &&
                     (lvl_diff >= -$signed({17'd0, tol_ff}));
   assign b_hit    = b_inb_ff && store_rdata[32] && (!same_ff || lvl_ok);
   assign mul_x    = $signed({b_dx_ff, 1'b1}) * $signed({1'b0, cs_eff});
   assign mul_z    = $signed({b_dz_ff, 1'b1}) * $signed({1'b0, cs_eff});
   assign ddx_in   = 27'(mul_x) - $signed({10'd0, remx_ff, 1'b0});
   assign ddz_in   = 27'(mul_z) - $signed({10'd0, remz_ff, 1'b0});

   logic               c_v_ff, c_last_ff, c_hit_ff;
   logic signed [26:0] c_ddx_ff, c_ddz_ff;
   logic [10:0]        c_cx_ff, c_cz_ff;
   logic [AW-1:0]      c_idx_ff;
   logic [31:0]        c_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else c_v_ff <= b_v_ff;
      c_last_ff <= b_last_ff;
      c_hit_ff  <= b_hit;
      c_ddx_ff  <= ddx_in;
      c_ddz_ff  <= ddz_in;
      c_cx_ff   <= b_cx_ff;
      c_cz_ff   <= b_cz_ff;
      c_idx_ff  <= b_idx_ff;
      c_lvl_ff  <= store_rdata[31:0];
   end

   // stage d: squares
   logic signed [53:0] sqx, sqz;
   assign sqx = c_ddx_ff * c_ddx_ff;
   assign sqz = c_ddz_ff * c_ddz_ff;

   logic          d_v_ff, d_last_ff, d_hit_ff;
   logic [52:0]   d_sx_ff, d_sz_ff;
   logic [10:0]   d_cx_ff, d_cz_ff;
   logic [AW-1:0] d_idx_ff;
   logic [31:0]   d_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else d_v_ff <= c_v_ff;
      d_last_ff <= c_last_ff;
      d_hit_ff  <= c_hit_ff;
      d_sx_ff   <= 53'(sqx);
      d_sz_ff   <= 53'(sqz);
      d_cx_ff   <= c_cx_ff;
      d_cz_ff   <= c_cz_ff;
      d_idx_ff  <= c_idx_ff;
      d_lvl_ff  <= c_lvl_ff;
   end

   // stage e: keep the first strict minimum
   logic          best_found_ff;
   logic [53:0]   best_d_ff, cand_dist;
   logic [10:0]   best_cx_ff, best_cz_ff;
   logic [AW-1:0] best_idx_ff;
   logic [31:0]   best_lvl_ff;
   logic          take, found_nx, ring_end;

   assign cand_dist = 54'(d_sx_ff) + 54'(d_sz_ff);
   assign take      = d_v_ff && d_hit_ff && (!best_found_ff || (cand_dist < best_d_ff));
   assign found_nx  = best_found_ff || (d_v_ff && d_hit_ff);
   assign ring_end  = d_v_ff && d_last_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff   <= cand_dist;
         best_cx_ff  <= d_cx_ff;
         best_cz_ff  <= d_cz_ff;
         best_idx_ff <= d_idx_ff;
         best_lvl_ff <= d_lvl_ff;
      end
   end

   // centre of the chosen cell
   logic [26:0]        px_ff, pz_ff;
   logic signed [34:0] sum_x, sum_z;
   logic [31:0]        sat_x, sat_z;
   logic               rsp_load;

   assign sum_x = 35'($signed(ox_ff)) + $signed({8'd0, px_ff}) +
                  $signed({20'd0, cs_eff[15:1]});
   assign sum_z = 35'($signed(oz_ff)) + $signed({8'd0, pz_ff}) +
                  $signed({20'd0, cs_eff[15:1]});
   assign sat_x = (sum_x > 35'sd2147483647) ? 32'h7fffffff :
                  (sum_x < -35'sd2147483648) ? 32'h80000000 : sum_x[31:0];
   assign sat_z = (sum_z > 35'sd2147483647) ? 32'h7fffffff :
                  (sum_z < -35'sd2147483648) ? 32'h80000000 : sum_z[31:0];
   assign rsp_load = (st_ff == S_FIN2) && (!rsp_v_ff || rsp_ch.ready);

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         gen_act_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         if (take) best_found_ff <= 1'b1;
         if (gen_act_ff) begin
            if (gen_last) begin
               gen_act_ff <= 1'b0;
            end else if (dx_ff == pos_r) begin
               dx_ff <= neg_r;
               dz_ff <= dz_ff + 8'sd1;
            end else if (edge_row) begin
               dx_ff <= dx_ff + 8'sd1;
            end else begin
               dx_ff <= pos_r;
            end
         end
         unique case (st_ff)
            S_IDLE: begin
               if (req_fire && is_query) begin
                  same_ff       <= (req_ch.operation == nwcs_pkg::OP_LEVEL);
                  qz_ff         <= req_ch.query_z;
                  best_found_ff <= 1'b0;
                  st_ff         <= S_DIVX;
               end
            end
            S_DIVX: begin
               if (div_done) begin
                  ccx_ff  <= div_res.quo;
                  remx_ff <= div_res.rem;
                  st_ff   <= S_DIVZ;
               end
            end
            S_DIVZ: begin
               if (div_done) begin
                  ccz_ff  <= div_res.quo;
                  remz_ff <= div_res.rem;
                  st_ff   <= S_REF;
               end
            end
            S_REF: begin
               rad_ff <= (rad_sel > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : rad_sel;
               if (!grid_ok_ff || (same_ff && !centre_in)) begin
                  st_ff <= S_FIN2;
               end else if (same_ff) begin
                  st_ff <= S_REFW;
               end else begin
                  r_ff       <= 7'd0;
                  dx_ff      <= 8'sd0;
                  dz_ff      <= 8'sd0;
                  gen_act_ff <= 1'b1;
                  st_ff      <= S_SCAN;
               end
            end
            S_REFW: begin
               ref_ff     <= store_rdata[31:0];
               r_ff       <= 7'd0;
               dx_ff      <= 8'sd0;
               dz_ff      <= 8'sd0;
               gen_act_ff <= 1'b1;
               st_ff      <= S_SCAN;
            end
            S_SCAN: begin
               if (ring_end) begin
                  if (found_nx || (r_ff == rad_ff)) begin
                     st_ff <= found_nx ? S_FIN1 : S_FIN2;
                  end else begin
                     r_ff       <= r_ff + 7'd1;
                     dx_ff      <= neg_r_nx;
                     dz_ff      <= neg_r_nx;
                     gen_act_ff <= 1'b1;
                  end
               end
            end
            S_FIN1: begin
               px_ff <= 27'(best_cx_ff) * 27'(cs_eff);
               pz_ff <= 27'(best_cz_ff) * 27'(cs_eff);
               st_ff <= S_FIN2;
            end
            S_FIN2: begin
               if (rsp_load) st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // output register
   logic        rsp_found_ff;
   logic [15:0] rsp_idx_ff;
   logic [31:0] rsp_x_ff, rsp_z_ff, rsp_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (rsp_load || (req_fire && !is_query)) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_ff <= 1'b0;
      end
      if (rsp_load && best_found_ff) begin
         rsp_found_ff <= 1'b1;
         rsp_idx_ff   <= 16'(best_idx_ff);
         rsp_x_ff     <= sat_x;
         rsp_z_ff     <= sat_z;
         rsp_h_ff     <= best_lvl_ff;
      end else if (rsp_load || (req_fire && !is_query)) begin
         rsp_found_ff <= 1'b0;
         rsp_idx_ff   <= 16'd0;
         rsp_x_ff     <= 32'd0;
         rsp_z_ff     <= 32'd0;
         rsp_h_ff     <= 32'd0;
      end
   end

   assign rsp_ch.valid          = rsp_v_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.out_cell_index = rsp_idx_ff;
   assign rsp_ch.out_x          = $signed(rsp_x_ff);
   assign rsp_ch.out_z          = $signed(rsp_z_ff);
   assign rsp_ch.out_height     = $signed(rsp_h_ff);

   // offsets are generated only while scanning
   a_gen_in_scan: assert property (@(posedge clock) disable iff (reset)
      gen_act_ff |-> (st_ff == S_SCAN))
      else $error("ring generator active outside scan");

   // a ring closes only after its last offset left the generator
   a_ring_drained: assert property (@(posedge clock) disable iff (reset)
      ring_end |-> !gen_act_ff)
      else $error("ring closed while offsets still issued");

   // a result appears only from a write or no-op transfer or the final step of a query
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past((st_ff == S_IDLE) || (st_ff == S_FIN2)))
      else $error("result raised from an unexpected state");

   // the store is never written by a request during a scan
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (st_ff == S_IDLE) && !clearing)
      else $error("cell write outside idle");

endmodule

// ----- bench/testbench.sv -----
module testbench;

   localparam int STORE_DEPTH = 65536;
   localparam int RADIUS_CAP  = 64;
   localparam int IDLE_LIMIT  = 200000;

   typedef struct {
      logic [1:0]         op;
      logic [15:0]        idx;
      logic               walk;
      logic               blk;
      logic signed [31:0] height;
      logic signed [31:0] qx;
      logic signed [31:0] qz;
      bit                 zero_result;   // expected result is all zero, typed in
   } cell_req_type;

   typedef struct {
      logic               found;
      logic [15:0]        idx;
      logic signed [31:0] x;
      logic signed [31:0] z;
      logic signed [31:0] height;
   } cell_rsp_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   nwcs_req_if req_bus ();
   nwcs_rsp_if rsp_bus ();

   nearest_walkable_cell_search_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the cell store and the registers
   bit                 usable_map [STORE_DEPTH];
   logic signed [31:0] level_map  [STORE_DEPTH];
   logic signed [31:0] org_x, org_z;
   logic [15:0]        csize;
   logic [10:0]        gw, gh;
   logic [6:0]         nrad, lrad;
   logic [15:0]        htol;

   cell_rsp_type pending_results [$];
   cell_req_type stim [$];
   int errors = 0;
   int n_items, n_phases;
   int n_results = 0;
   int n_hits = 0;
   int idle_cycles = 0;
   int ready_pct = 100;
   int stall_timer = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // append to the queues
   function automatic void queue_stim(cell_req_type it);
      stim = {stim, it};
   endfunction

   function automatic void queue_result(cell_rsp_type r);
      pending_results = {pending_results, r};
   endfunction

   // apply one request to the shadow store and work out its result
   function automatic cell_rsp_type search_cell(cell_req_type it);
      cell_rsp_type res;
      longint w, h, cs, qx, qz, ox, oz, ccx, ccz, rad, r, dx, dz, cx, cz;
      longint base_lv, diff, ddx, ddz, bx, bz, cidx, best_idx;
      longint unsigned ux, uz, cand_d, best_d;
      bit lvl, hit;
      res = '{found: 1'b0, idx: '0, x: '0, z: '0, height: '0};
      if (it.op == nwcs_pkg::OP_WRITE) begin
         usable_map[it.idx] = it.walk && !it.blk;
         level_map[it.idx] = it.height;
         return res;
      end
      if (it.op == nwcs_pkg::OP_NONE) return res;
      w = gw;
      h = gh;
      if (w == 0 || h == 0 || w * h > STORE_DEPTH) return res;
      qx = longint'(it.qx);
      qz = longint'(it.qz);
      ox = longint'(org_x);
      oz = longint'(org_z);
      cs = (csize == 0) ? 1 : csize;
      ccx = floor_quot(qx - ox, cs);
      ccz = floor_quot(qz - oz, cs);
      lvl = (it.op == nwcs_pkg::OP_LEVEL);
      rad = lvl ? lrad : nrad;
      if (rad > RADIUS_CAP) rad = RADIUS_CAP;
      base_lv = 0;
      if (lvl) begin
         if (ccx < 0 || ccz < 0 || ccx >= w || ccz >= h) return res;
         base_lv = longint'(level_map[ccz * w + ccx]);
      end
      hit = 0;
      best_d = 0;
      best_idx = 0;
      bx = 0;
      bz = 0;
      // walk each ring border only: interior rows jump straight to the right edge
      for (r = 0; r <= rad && !hit; r++) begin
         for (dz = -r; dz <= r; dz++) begin
            dx = -r;
            while (dx <= r) begin
               cx = ccx + dx;
               cz = ccz + dz;
               if (cx >= 0 && cz >= 0 && cx < w && cz < h) begin
                  cidx = cz * w + cx;
                  diff = 0;
                  if (lvl) begin
                     diff = longint'(level_map[cidx]) - base_lv;
                     if (diff < 0) diff = -diff;
                  end
                  if (usable_map[cidx] && diff <= longint'(htol)) begin
                     ddx = 2 * ox + (2 * cx + 1) * cs - 2 * qx;
                     ddz = 2 * oz + (2 * cz + 1) * cs - 2 * qz;
                     ux = (ddx < 0) ? -ddx : ddx;
                     uz = (ddz < 0) ? -ddz : ddz;
                     cand_d = ux * ux + uz * uz;
                     if (!hit || cand_d < best_d) begin
                        best_d = cand_d;
                        best_idx = cidx;
                        bx = cx;
                        bz = cz;
                        hit = 1;
                     end
                  end
               end
               if (dz == -r || dz == r || dx == r) dx = dx + 1;
               else dx = r;
            end
         end
      end
      if (hit) begin
         res.found = 1'b1;
         res.idx = best_idx[15:0];
         res.x = clamp32(floor_quot(2 * ox + (2 * bx + 1) * cs, 2));
         res.z = clamp32(floor_quot(2 * oz + (2 * bz + 1) * cs, 2));
         res.height = level_map[best_idx];
      end
      return res;
   endfunction

   function automatic cell_req_type mk_req(logic [1:0] op, logic [15:0] idx, logic walk,
                                           logic blk, logic [31:0] height, logic [31:0] qx,
                                           logic [31:0] qz, bit zero_result);
      cell_req_type it;
      it.op = op;
      it.idx = idx;
      it.walk = walk;
      it.blk = blk;
      it.height = height;
      it.qx = qx;
      it.qz = qz;
      it.zero_result = zero_result;
      return it;
   endfunction

   // random request aimed mostly at the configured grid
   function automatic cell_req_type rand_req();
      cell_req_type it;
      longint cs, cells, pt;
      int pick;
      cs = (csize == 0) ? 1 : csize;
      cells = longint'(gw) * longint'(gh);
      it.zero_result = 0;
      it.idx = 16'($urandom);
      it.walk = ($urandom_range(0, 9) < 7);
      it.blk = ($urandom_range(0, 9) < 2);
      it.height = $urandom;
      it.qx = $urandom;
      it.qz = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) it.op = nwcs_pkg::OP_WRITE;
      else if (pick < 70) it.op = nwcs_pkg::OP_NEAR;
      else if (pick < 95) it.op = nwcs_pkg::OP_LEVEL;
      else it.op = nwcs_pkg::OP_NONE;
      if (it.op == nwcs_pkg::OP_WRITE && cells > 0 && cells <= STORE_DEPTH &&
          $urandom_range(0, 9) != 0)
         it.idx = 16'($urandom_range(0, int'(cells - 1)));
      if ($urandom_range(0, 3) != 0)
         it.height = $signed($urandom_range(0, 2 * htol + 2)) - $signed({16'd0, htol});
      if ($urandom_range(0, 9) != 0) begin
         pt = longint'(org_x) + ($signed($urandom_range(0, gw + 3)) - 2) * cs
              + $urandom_range(0, int'(cs - 1));
         it.qx = pt[31:0];
         pt = longint'(org_z) + ($signed($urandom_range(0, gh + 3)) - 2) * cs
              + $urandom_range(0, int'(cs - 1));
         it.qz = pt[31:0];
      end
      return it;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   // drive one register write; the caller drops the enable after the last one
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         nwcs_pkg::REG_ORIGIN_X:   org_x = value;
         nwcs_pkg::REG_ORIGIN_Z:   org_z = value;
         nwcs_pkg::REG_CELL_SIZE:  csize = value[15:0];
         nwcs_pkg::REG_GRID_W:     gw = value[10:0];
         nwcs_pkg::REG_GRID_H:     gh = value[10:0];
         nwcs_pkg::REG_NEAR_RAD:   nrad = value[6:0];
         nwcs_pkg::REG_LEVEL_RAD:  lrad = value[6:0];
         nwcs_pkg::REG_HEIGHT_TOL: htol = value[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // send every queued request in bursts with random gaps
   task automatic send_all();
      cell_req_type it;
      int burst;
      burst = 0;
      while (stim.size() != 0) begin
         it = stim.pop_front();
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
               req_bus.valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         burst--;
         req_bus.valid <= 1'b1;
         req_bus.operation <= it.op;
         req_bus.cell_index <= it.idx;
         req_bus.base_walkable <= it.walk;
         req_bus.blocked <= it.blk;
         req_bus.cell_height <= it.height;
         req_bus.query_x <= it.qx;
         req_bus.query_z <= it.qz;
         do @(posedge clock); while (!req_bus.ready);
         n_items++;
         if (it.zero_result) begin
            void'(search_cell(it));
            queue_result('{found: 1'b0, idx: '0, x: '0, z: '0, height: '0});
         end else begin
            queue_result(search_cell(it));
         end
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] ox, logic [31:0] oz, logic [31:0] cs,
                            logic [31:0] w, logic [31:0] h, logic [31:0] nr,
                            logic [31:0] lr, logic [31:0] tol, int count);
      wait_drained();
      write_reg(nwcs_pkg::REG_ORIGIN_X, ox);
      write_reg(nwcs_pkg::REG_ORIGIN_Z, oz);
      write_reg(nwcs_pkg::REG_CELL_SIZE, cs);
      write_reg(nwcs_pkg::REG_GRID_W, w);
      write_reg(nwcs_pkg::REG_GRID_H, h);
      write_reg(nwcs_pkg::REG_NEAR_RAD, nr);
      write_reg(nwcs_pkg::REG_LEVEL_RAD, lr);
      write_reg(nwcs_pkg::REG_HEIGHT_TOL, tol);
      csr_we <= 1'b0;
      repeat (count) queue_stim(rand_req());
      send_all();
      n_phases++;
   endtask

   // result checker, receiver stall pattern and watchdog
   always @(posedge clock) begin
      cell_rsp_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_bus.found), 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.found) n_hits++;
               if (rsp_bus.found !== want.found)
                  report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
               if (rsp_bus.out_cell_index !== want.idx)
                  report_mismatch("out_cell_index", 32'(rsp_bus.out_cell_index),
                                  32'(want.idx));
               if (rsp_bus.out_x !== want.x) report_mismatch("out_x", rsp_bus.out_x, want.x);
               if (rsp_bus.out_z !== want.z) report_mismatch("out_z", rsp_bus.out_z, want.z);
               if (rsp_bus.out_height !== want.height)
                  report_mismatch("out_height", rsp_bus.out_height, want.height);
            end
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("nearest_walkable_cell_search_core test failed");
            $finish;
         end
      end
      // change the stall mix whenever the stall timer runs out
      stall_timer++;
      if (stall_timer >= 300) begin
         stall_timer = 0;
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 40;
            default: ready_pct = 10;
         endcase
      end
      rsp_bus.ready <= ($urandom_range(0, 99) < ready_pct);
   end

   initial begin
      n_items = 0;
      n_phases = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= nwcs_pkg::REG_ORIGIN_X;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.operation <= nwcs_pkg::OP_WRITE;
      req_bus.cell_index <= '0;
      req_bus.base_walkable <= 1'b0;
      req_bus.blocked <= 1'b0;
      req_bus.cell_height <= '0;
      req_bus.query_x <= '0;
      req_bus.query_z <= '0;
      org_x = 0;
      org_z = 0;
      csize = 256;
      gw = 256;
      gh = 256;
      nrad = 12;
      lrad = 20;
      htol = 256;
      foreach (usable_map[i]) begin
         usable_map[i] = 0;
         level_map[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 0, 0, 1));       // empty store
      queue_stim(mk_req(nwcs_pkg::OP_LEVEL, 0, 0, 0, 0, 0, 0, 1));
      queue_stim(mk_req(nwcs_pkg::OP_WRITE, 0, 1, 0, 0, 0, 0, 1));
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 0, 0, 0));
      queue_stim(mk_req(nwcs_pkg::OP_WRITE, 16'hFFFF, 1, 0, 32'h7FFFFFFF, 0, 0, 1));
      queue_stim(mk_req(nwcs_pkg::OP_WRITE, 1, 1, 1, 100, 0, 0, 1));    // blocked cell
      queue_stim(mk_req(nwcs_pkg::OP_WRITE, 2, 0, 0, 50, 0, 0, 1));     // not walkable
      queue_stim(mk_req(nwcs_pkg::OP_NONE, 5, 1, 0, 77, 300, 300, 1));  // does nothing
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 255 * 256 + 10, 255 * 256 + 200, 0));
      queue_stim(mk_req(nwcs_pkg::OP_LEVEL, 0, 0, 0, 0, 255 * 256, 255 * 256, 0));
      queue_stim(mk_req(nwcs_pkg::OP_LEVEL, 0, 0, 0, 0, 300, 0, 0));
      queue_stim(mk_req(nwcs_pkg::OP_WRITE, 3, 1, 0, 32'h80000000, 0, 0, 1));
      queue_stim(mk_req(nwcs_pkg::OP_LEVEL, 0, 0, 0, 0, 3 * 256 + 1, 255, 0));
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0));
      queue_stim(mk_req(nwcs_pkg::OP_NEAR, 0, 0, 0, 0, 256, 128, 0));   // on a cell border
      queue_stim(mk_req(nwcs_pkg::OP_LEVEL, 0, 0, 0, 0, -10, 100, 1));  // centre off grid
      send_all();
      repeat (60) queue_stim(rand_req());
      send_all();

      // random part over several settings
      run_phase(-5000, 7777, 100, 40, 30, 5, 7, 300, 70);
      run_phase(0, 0, 0, 16, 16, 3, 3, 0, 40);                          // zero cell size
      run_phase(32'h7FFF0000, 32'h80000000, 65535, 64, 64, 8, 10, 65535, 45);
      run_phase(0, 0, 256, 1024, 1024, 12, 20, 256, 15);                // grid too large
      run_phase(0, 0, 256, 0, 5, 12, 20, 256, 10);                      // zero width
      run_phase(123, -456, 256, 8, 8, 0, 0, 1000, 40);
      run_phase(0, 0, 1, 1024, 64, 100, 64, 0, 10);                     // radius clamp
      run_phase(-1, 1, 255, 1, 1, 2, 2, 256, 30);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d requests in %0d setting phases after the reset phase",
               n_items, n_phases);
      $display("checked %0d results, %0d of them hits", n_results, n_hits);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("nearest_walkable_cell_search_core test passed");
      end else begin
         $display("nearest_walkable_cell_search_core test failed");
      end
      $finish;
   end

endmodule
